### rtl/core/ple_pkg.sv
// Shared types and codes for the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

  // Request action codes
  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_DELETE   = 2'd1;
  localparam logic [1:0] ACT_COUNT    = 2'd2;
  localparam logic [1:0] ACT_TRAVERSE = 2'd3;

  // Response status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Cell operations
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_DELETE = 2'd2;
  localparam logic [1:0] CELL_ROTATE = 2'd3;

  localparam int PosW   = 8;
  localparam int ValW   = 32;
  localparam int CountW = 5;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic [1:0]      op;
    logic [PosW-1:0] pos;   // 0-based slot for insert/delete
    logic [PosW-1:0] tail;  // slot of the last entry, used by rotate
  } cell_ctl_t;

endpackage

### rtl/core/ple_if.sv
// Request and response channel interfaces for the positional list engine.
`timescale 1ns / 1ps
interface ple_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic signed [ple_pkg::ValW-1:0]   value;
  logic [ple_pkg::PosW-1:0]          position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

interface ple_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [ple_pkg::CountW-1:0]        entry_count;
  logic signed [ple_pkg::ValW-1:0]   entry_value;
  logic                              has_value;
  logic                              last;

  modport source (output valid, status, entry_count, entry_value, has_value, last,
                  input ready);
  modport sink   (input valid, status, entry_count, entry_value, has_value, last,
                  output ready);
endinterface

### rtl/core/ple_cell.sv
// One storage cell of the list chain.
`timescale 1ns / 1ps
module ple_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  ple_pkg::cell_ctl_t                ctl,
  input  logic signed [ple_pkg::ValW-1:0]   ins_value,
  input  logic signed [ple_pkg::ValW-1:0]   left,
  input  logic signed [ple_pkg::ValW-1:0]   right,
  input  logic signed [ple_pkg::ValW-1:0]   head,
  output logic signed [ple_pkg::ValW-1:0]   data
);

  localparam logic [ple_pkg::PosW-1:0] MyIdx = ple_pkg::PosW'(IDX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      ple_pkg::CELL_INSERT: begin
        if (MyIdx > ctl.pos) begin
          data <= left;
        end else if (MyIdx == ctl.pos) begin
          data <= ins_value;
        end
      end
      ple_pkg::CELL_DELETE: begin
        if (MyIdx >= ctl.pos) begin
          data <= right;
        end
      end
      ple_pkg::CELL_ROTATE: begin
        // head wraps to the tail slot, everything else moves toward slot 0
        if (MyIdx == ctl.tail) begin
          data <= head;
        end else begin
          data <= right;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

### rtl/core/positional_list_engine.sv
// Top level of the positional list engine: cell chain, count and response register.
// Insert, delete and count answer in the cycle after the request transaction.
// Throughput: one request per cycle for insert, delete and count while responses drain;
//   traverse of N entries emits one entry per cycle while responses drain, set by the
//   rotation of the cell chain, which walks the list past the head cell.
// Reset: synchronous active-high rst empties the list; entry storage is not cleared.
`timescale 1ns / 1ps
module positional_list_engine #(
  parameter int DEPTH = 16
) (
  input logic          clk,
  input logic          rst,
  ple_req_if.sink      req,
  ple_rsp_if.source    rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ple_pkg::PosW;
  localparam int VW = ple_pkg::ValW;

  // Controller states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                 state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        remain, remain_next;

  // response register
  logic                 out_valid, out_valid_next;
  logic [1:0]           out_status, out_status_next;
  logic signed [VW-1:0] out_value, out_value_next;
  logic                 out_has, out_has_next;
  logic                 out_last, out_last_next;

  ple_pkg::cell_ctl_t   ctl;
  logic signed [VW-1:0] cell_q [DEPTH];

  logic out_free;
  logic req_fire;
  logic [PW:0] pos_ext;
  logic [PW:0] count_ext;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign req_fire  = req.valid && req.ready;
  assign pos_ext   = {1'b0, req.position};
  assign count_ext = (PW + 1)'(count);

  // The chain of cells; each takes from its neighbors under the shared control.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VW-1:0] left_d;
    logic signed [VW-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = req.value;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_lastc
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    ple_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .ins_value (req.value),
      .left      (left_d),
      .right     (right_d),
      .head      (cell_q[0]),
      .data      (cell_q[i])
    );
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    remain_next     = remain;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_value_next  = out_value;
    out_has_next    = out_has;
    out_last_next   = out_last;
    ctl.op          = ple_pkg::CELL_HOLD;
    ctl.pos         = req.position - PW'(1);
    ctl.tail        = PW'(count) - PW'(1);

    if (req_fire) begin
      out_valid_next  = 1'b1;
      out_status_next = ple_pkg::ST_OK;
      out_value_next  = '0;
      out_has_next    = 1'b0;
      out_last_next   = 1'b1;
      case (req.action)
        ple_pkg::ACT_INSERT: begin
          if (req.position == '0 || pos_ext > count_ext + (PW + 1)'(1)) begin
            out_status_next = ple_pkg::ST_BADPOS;
          end else if (count == CW'(DEPTH)) begin
            out_status_next = ple_pkg::ST_FULL;
          end else begin
            ctl.op     = ple_pkg::CELL_INSERT;
            count_next = count + CW'(1);
          end
        end
        ple_pkg::ACT_DELETE: begin
          if (count == '0) begin
            out_status_next = ple_pkg::ST_EMPTY;
          end else if (req.position == '0 || pos_ext > count_ext) begin
            out_status_next = ple_pkg::ST_BADPOS;
          end else begin
            ctl.op     = ple_pkg::CELL_DELETE;
            count_next = count - CW'(1);
          end
        end
        ple_pkg::ACT_TRAVERSE: begin
          // non-empty list: emit entries from the WALK state instead
          if (count != '0) begin
            out_valid_next = 1'b0;
            state_next     = ST_WALK;
            remain_next    = count;
          end
        end
        default: begin
          // count: plain ok response
        end
      endcase
    end else if (state == ST_WALK && out_free) begin
      // emit the head and rotate; after count steps the order is restored
      ctl.op          = ple_pkg::CELL_ROTATE;
      out_valid_next  = 1'b1;
      out_status_next = ple_pkg::ST_OK;
      out_value_next  = cell_q[0];
      out_has_next    = 1'b1;
      out_last_next   = (remain == CW'(1));
      remain_next     = remain - CW'(1);
      if (remain == CW'(1)) begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remain    <= remain_next;
      out_valid <= out_valid_next;
    end
    out_status <= out_status_next;
    out_value  <= out_value_next;
    out_has    <= out_has_next;
    out_last   <= out_last_next;
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_count = ple_pkg::CountW'(count);
  assign rsp.entry_value = out_value;
  assign rsp.has_value   = out_has;
  assign rsp.last        = out_last;

endmodule

### rtl/core/ple_checker.sv
// Port-level checks for the positional list engine, bound to the top level.
`timescale 1ns / 1ps
module ple_checker #(
  parameter int DEPTH = 16
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [1:0]                      rsp_status,
  input logic [ple_pkg::CountW-1:0]      rsp_entry_count,
  input logic signed [ple_pkg::ValW-1:0] rsp_entry_value,
  input logic                            rsp_has_value,
  input logic                            rsp_last
);

  // a stalled response keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_entry_value) && $stable(rsp_last) && $stable(rsp_has_value))
    else $error("response changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (DEPTH > 31) || (rsp_entry_count <= ple_pkg::CountW'(DEPTH)))
    else $error("entry count above depth");

  a_mid_walk: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_has_value && rsp_status == ple_pkg::ST_OK && !req_ready)
    else $error("non-final response outside a traverse");

  a_no_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_has_value |-> rsp_entry_value == '0 && rsp_last)
    else $error("value on a response without an entry");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_entry_count (rsp.entry_count),
  .rsp_entry_value (rsp.entry_value),
  .rsp_has_value   (rsp.has_value),
  .rsp_last        (rsp.last)
);
